### rtl/vgt_pkg.sv
// Shared types, constants and split tables for the voxel grid tetrahedralizer.
`default_nettype none
package vgt_pkg;

	localparam int CNT_W     = 7;
	localparam int CELL_W    = 6;
	localparam int ID_W      = 18;
	localparam int ROW_W     = 20;
	localparam int MAX_DIM   = 64;
	localparam int TETS      = 5;
	localparam int SLOT_W    = 3;
	localparam int PLANE_W   = 13;
	localparam int AREA_W    = 12;
	localparam int SPAN_W    = 6;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = 2;
	localparam int Q_CNT_W   = 3;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_COUNT_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COUNT_Z = 2'd2;

	localparam logic [CNT_W-1:0] COUNT_RESET = 7'd2;

	typedef logic [2:0] corner_t;

	// corner rows, already reversed
	localparam corner_t ODD_SPLIT [TETS][4] = '{
		'{3'd2, 3'd5, 3'd0, 3'd1},
		'{3'd6, 3'd7, 3'd2, 3'd5},
		'{3'd4, 3'd5, 3'd0, 3'd7},
		'{3'd3, 3'd7, 3'd0, 3'd2},
		'{3'd2, 3'd7, 3'd0, 3'd5}
	};
	localparam corner_t EVEN_SPLIT [TETS][4] = '{
		'{3'd0, 3'd4, 3'd1, 3'd3},
		'{3'd2, 3'd3, 3'd1, 3'd6},
		'{3'd5, 3'd6, 3'd1, 3'd4},
		'{3'd7, 3'd4, 3'd3, 3'd6},
		'{3'd4, 3'd6, 3'd1, 3'd3}
	};

	typedef struct packed {
		logic [ID_W-1:0]  base_id;
		logic [ROW_W-1:0] row_base;
		logic             odd;
		logic             bad;
	} cell_t;

	typedef struct packed {
		logic [PLANE_W-1:0] plane;
		logic [CNT_W-1:0]   line;
	} geom_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = (v > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : v;
		return r;
	endfunction

	// corner n: dx = n0^n1, dy = n1, dz = n2
	function automatic logic [ID_W-1:0] corner_id(input logic [ID_W-1:0] base,
			input geom_t g, input corner_t n);
		logic [ID_W-1:0] sum;
		sum = base + ((n[0] ^ n[1]) ? ID_W'(g.plane) : '0)
			+ (n[1] ? ID_W'(g.line) : '0) + ID_W'(n[2]);
		return sum;
	endfunction

endpackage
`default_nettype wire

### rtl/voxel_grid_tetrahedralizer_unit.sv
// Top level of the voxel grid tetrahedralizer.
// Usage:
//   cfg_wr_en/cfg_index/cfg_data write count_x (0), count_y (1), count_z (2);
//   values above 64 saturate. Write only while the unit is idle.
//   Slave channel takes one cell (i,j,k) per word; master channel gives one
//   word per tetrahedron: five for a cell inside the grid, last on the fifth,
//   or a single word with tuser (bad_cell) and tlast set and zero ids.
// Throughput: one result word per cycle while m_tready is high and cells wait; the
//   back end tetrahedron walk gives five words per valid cell and one per bad cell.
// A two-stage front end and a 4-entry queue sit ahead of the back end, so
//   cells keep being accepted while results wait on m_tready.
// Reset: counts return to 2, all pipeline, queue and output state is
//   emptied. A stalled receiver holds the output word; the queue then fills
//   and s_tready drops.
`default_nettype none
module voxel_grid_tetrahedralizer_unit
	import vgt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [23:0]          s_tdata,  // cell_i, cell_j, cell_k
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [95:0]               m_tdata,  // corner_a..corner_d, tet_row
	output logic                      m_tuser,  // bad_cell
	output logic                      m_tlast
);

	logic             push, full, pop, head_valid;
	cell_t            push_data, head;
	geom_t            geom;
	logic [ID_W-1:0]  corner_a, corner_b, corner_c, corner_d;
	logic [ROW_W-1:0] tet_row;

	vgt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cell_i    (s_tdata[5:0]),
		.cell_j    (s_tdata[11:6]),
		.cell_k    (s_tdata[17:12]),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.geom      (geom)
	);

	vgt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	vgt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.geom       (geom),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.corner_a   (corner_a),
		.corner_b   (corner_b),
		.corner_c   (corner_c),
		.corner_d   (corner_d),
		.tet_row    (tet_row),
		.bad_cell   (m_tuser),
		.last       (m_tlast)
	);

	assign m_tdata = {4'b0000, tet_row, corner_d, corner_c, corner_b, corner_a};

endmodule
`default_nettype wire

### rtl/vgt_front.sv
// Front end: grid registers, cell check and base id / row computation.
`default_nettype none
module vgt_front
	import vgt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CELL_W-1:0]    cell_i,
	input  wire logic [CELL_W-1:0]    cell_j,
	input  wire logic [CELL_W-1:0]    cell_k,
	output logic                      push,
	output cell_t                     push_data,
	input  wire logic                 full,
	output geom_t                     geom
);

	logic [CNT_W-1:0]   nx_q, ny_q, nz_q;
	logic [PLANE_W-1:0] plane_q;
	logic [AREA_W-1:0]  area_q;
	logic [SPAN_W-1:0]  zm1_q;

	logic [CNT_W-1:0]   wv;
	logic [2*CNT_W-1:0] plane_y, plane_z, area_y, area_z;
	logic [CNT_W-1:0]   wv_m1, ny_m1, nz_m1;

	logic                   v1_s1, v2_s2;
	logic [ID_W:0]          pa_s1;
	logic [PLANE_W-1:0]     pb_s1;
	logic [ID_W-1:0]        pr_s1;
	logic [AREA_W-1:0]      ps_s1;
	logic [CELL_W-1:0]      ck_s1;
	logic                   odd_s1, bad_s1;
	cell_t                  cell_s2;
	logic                   en1, en2;
	logic [ID_W:0]          cell_lin;
	logic [ROW_W-1:0]       row5;

	assign wv      = clamp_count(cfg_data);
	assign wv_m1   = wv - 1'b1;
	assign ny_m1   = ny_q - 1'b1;
	assign nz_m1   = nz_q - 1'b1;
	assign plane_y = (2*CNT_W)'(wv) * (2*CNT_W)'(nz_q);
	assign plane_z = (2*CNT_W)'(ny_q) * (2*CNT_W)'(wv);
	assign area_y  = (2*CNT_W)'(wv_m1) * (2*CNT_W)'(nz_m1);
	assign area_z  = (2*CNT_W)'(ny_m1) * (2*CNT_W)'(wv_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q    <= COUNT_RESET;
			ny_q    <= COUNT_RESET;
			nz_q    <= COUNT_RESET;
			plane_q <= PLANE_W'(4);
			area_q  <= AREA_W'(1);
			zm1_q   <= SPAN_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COUNT_X: nx_q <= wv;
				REG_COUNT_Y: begin
					ny_q    <= wv;
					plane_q <= PLANE_W'(plane_y);
					area_q  <= AREA_W'(area_y);
				end
				REG_COUNT_Z: begin
					nz_q    <= wv;
					plane_q <= PLANE_W'(plane_z);
					area_q  <= AREA_W'(area_z);
					zm1_q   <= SPAN_W'(wv_m1);
				end
				default: ;
			endcase
		end
	end

	assign geom.plane = plane_q;
	assign geom.line  = nz_q;

	assign push     = v2_s2 && !full;
	assign en2      = !v2_s2 || !full;
	assign en1      = !v1_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= in_valid;
			if (en2) v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			pa_s1  <= (ID_W+1)'(cell_i) * (ID_W+1)'(plane_q);
			pb_s1  <= PLANE_W'(cell_j) * PLANE_W'(nz_q);
			pr_s1  <= ID_W'(cell_i) * ID_W'(area_q);
			ps_s1  <= AREA_W'(cell_j) * AREA_W'(zm1_q);
			ck_s1  <= cell_k;
			odd_s1 <= cell_i[0] ^ cell_j[0] ^ cell_k[0];
			bad_s1 <= !(({1'b0, cell_i} + 1'b1) < nx_q && ({1'b0, cell_j} + 1'b1) < ny_q
				&& ({1'b0, cell_k} + 1'b1) < nz_q);
		end
	end

	assign cell_lin = (ID_W+1)'(pr_s1) + (ID_W+1)'(ps_s1) + (ID_W+1)'(ck_s1);
	assign row5     = ROW_W'(cell_lin) + ROW_W'({cell_lin, 2'b00});

	always_ff @(posedge clk) begin
		if (en2 && v1_s1) begin
			cell_s2.base_id  <= ID_W'(pa_s1 + (ID_W+1)'(pb_s1) + (ID_W+1)'(ck_s1));
			cell_s2.row_base <= row5;
			cell_s2.odd      <= odd_s1;
			cell_s2.bad      <= bad_s1;
		end
	end

	assign push_data = cell_s2;

endmodule
`default_nettype wire

### rtl/vgt_queue.sv
// Short queue of classified cells between front and back.
`default_nettype none
module vgt_queue
	import vgt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cell_t     push_data,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output cell_t     head
);

	cell_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full       = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

### rtl/vgt_back.sv
// Back end: walks a cell's five tetrahedra (one word if bad) into the output register.
`default_nettype none
module vgt_back
	import vgt_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  cell_t              head,
	output logic               pop,
	input  geom_t              geom,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [ID_W-1:0]    corner_a,
	output logic [ID_W-1:0]    corner_b,
	output logic [ID_W-1:0]    corner_c,
	output logic [ID_W-1:0]    corner_d,
	output logic [ROW_W-1:0]   tet_row,
	output logic               bad_cell,
	output logic               last
);

	cell_t             cur_q;
	logic              cur_v_q;
	logic [SLOT_W-1:0] slot_q;
	logic              adv, fin;
	corner_t           n0, n1, n2, n3;

	logic              out_v_q;
	logic [ID_W-1:0]   a_q, b_q, c_q, d_q;
	logic [ROW_W-1:0]  row_q;
	logic              bad_q, last_q;

	assign adv = cur_v_q && (!out_v_q || out_ready);
	assign fin = adv && (cur_q.bad || slot_q == SLOT_W'(TETS - 1));
	assign pop = head_valid && (!cur_v_q || fin);

	always_comb begin
		if (cur_q.odd) begin
			n0 = ODD_SPLIT[slot_q][0];
			n1 = ODD_SPLIT[slot_q][1];
			n2 = ODD_SPLIT[slot_q][2];
			n3 = ODD_SPLIT[slot_q][3];
		end else begin
			n0 = EVEN_SPLIT[slot_q][0];
			n1 = EVEN_SPLIT[slot_q][1];
			n2 = EVEN_SPLIT[slot_q][2];
			n3 = EVEN_SPLIT[slot_q][3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			slot_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_v_q <= 1'b1;
				slot_q  <= '0;
			end else if (fin) begin
				cur_v_q <= 1'b0;
			end else if (adv) begin
				slot_q <= slot_q + 1'b1;
			end
			if (adv) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (adv) begin
			bad_q  <= cur_q.bad;
			last_q <= fin;
			if (cur_q.bad) begin
				a_q   <= '0;
				b_q   <= '0;
				c_q   <= '0;
				d_q   <= '0;
				row_q <= '0;
			end else begin
				a_q   <= corner_id(cur_q.base_id, geom, n0);
				b_q   <= corner_id(cur_q.base_id, geom, n1);
				c_q   <= corner_id(cur_q.base_id, geom, n2);
				d_q   <= corner_id(cur_q.base_id, geom, n3);
				row_q <= cur_q.row_base + ROW_W'(slot_q);
			end
		end
	end

	assign out_valid = out_v_q;
	assign corner_a  = a_q;
	assign corner_b  = b_q;
	assign corner_c  = c_q;
	assign corner_d  = d_q;
	assign tet_row   = row_q;
	assign bad_cell  = bad_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> slot_q < SLOT_W'(TETS))
		else $error("slot counter out of range");
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && bad_q |-> last_q && row_q == '0 && a_q == '0)
		else $error("bad cell word not single and zeroed");
	a_last_on_fifth: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !cur_q.bad |=> last_q == ($past(slot_q) == SLOT_W'(TETS - 1)))
		else $error("last flag on wrong slot");
`endif

endmodule
`default_nettype wire
